// ----- design/tms_pkg.sv -----
// ----------------------------------------------------------------------------
// tms_pkg
// Shared types and codes for the triangle midpoint subdivider.
// ----------------------------------------------------------------------------
package tms_pkg;

  localparam int unsigned IdxW = 10;
  localparam int unsigned OutCoordW = 24;

  typedef enum logic [1:0] {
    MODE_LOAD  = 2'd0,
    MODE_SUBDIV = 2'd1,
    MODE_PASS  = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_REQ,
    ST_RD_WAIT,
    ST_RD_LATCH,
    ST_MID,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_INS,
    ST_EMIT_V,
    ST_EMIT_T
  } state_e;

endpackage

// ----- design/tms_ram.sv -----
// ----------------------------------------------------------------------------
// tms_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tms_ram #(
  parameter int unsigned Width = 72,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/triangle_midpoint_subdivider_unit.sv -----
// ----------------------------------------------------------------------------
// triangle_midpoint_subdivider_unit
// Splits a triangle into four through its edge midpoints, reusing midpoints.
// ----------------------------------------------------------------------------
// Loads and pass starts complete in the cycle of their transfer, and the
// block stays ready for the next item. A subdivide reads its three corners
// from the vertex RAM, each through a request, a wait and a latch state. It
// then forms the three midpoints and scans the dict_count entries of the
// midpoint dictionary, at most DICT_DEPTH, one entry a cycle through its
// single read port. It then looks up or writes each midpoint in turn; each
// new midpoint is emitted as a vertex result before the next one is taken,
// and the four triangle results follow: four to seven results in all, each
// held until transferred. The block accepts no item while a subdivide is in
// flight. Both RAMs hold nothing valid after reset and need no clearing.
// ----------------------------------------------------------------------------
module triangle_midpoint_subdivider_unit #(
  parameter int unsigned MAX_VERTS  = 1024,
  parameter int unsigned DICT_DEPTH = 512,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // idx_a[9:0], idx_b[19:10], idx_c[29:20], load_x[53:30], load_y[77:54],
  // load_z[101:78]
  input  logic [103:0] s_axis_tdata,
  // mode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_i0[9:0], out_i1[19:10], out_i2[29:20], out_x[53:30], out_y[77:54],
  // out_z[101:78], full_res[102]
  output logic [103:0] m_axis_tdata,
  // kind
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);
  import tms_pkg::*;

  localparam int unsigned VaW = $clog2(MAX_VERTS);
  localparam int unsigned DaW = $clog2(DICT_DEPTH);
  localparam int unsigned CntW = DaW + 1;
  localparam int unsigned NxW = (VaW > IdxW ? VaW : IdxW) + 1;
  localparam int unsigned VecW = 3 * COORD_BITS;

  typedef logic signed [COORD_BITS-1:0] crd_t;

  // input fields
  mode_e            in_mode;
  logic [IdxW-1:0]  in_a, in_b, in_c;
  assign in_mode = mode_e'(s_axis_tuser);
  assign in_a = s_axis_tdata[9:0];
  assign in_b = s_axis_tdata[19:10];
  assign in_c = s_axis_tdata[29:20];

  state_e state_q, state_d;
  logic [IdxW-1:0] ia_q, ib_q, ic_q;
  logic [1:0]      cnt_q, cnt_d;       // corner / edge / triangle counter
  logic [CntW-1:0] dcnt_q, dcnt_d;     // dictionary fill
  logic [NxW-1:0]  base_q, base_d, nxt_q, nxt_d;
  logic [CntW-1:0] n0_q, n0_d, scan_q, scan_d;
  crd_t            cx_q [3];
  crd_t            mx_q [3], my_q [3], mz_q [3];
  logic [2:0]      found_q;
  logic [IdxW-1:0] midx_q [3];
  logic            full_q;

  // vertex RAM
  logic            v_we;
  logic [VaW-1:0]  v_wa, v_ra;
  logic [VecW-1:0] v_wd, v_rd;
  tms_ram #(.Width(VecW), .Depth(MAX_VERTS)) u_vram (
    .clk_i(clk_i), .we_i(v_we), .waddr_i(v_wa), .wdata_i(v_wd),
    .raddr_i(v_ra), .rdata_o(v_rd)
  );
  // dictionary RAM
  logic            d_we;
  logic [DaW-1:0]  d_wa, d_ra;
  logic [VecW-1:0] d_wd, d_rd;
  tms_ram #(.Width(VecW), .Depth(DICT_DEPTH)) u_dram (
    .clk_i(clk_i), .we_i(d_we), .waddr_i(d_wa), .wdata_i(d_wd),
    .raddr_i(d_ra), .rdata_o(d_rd)
  );

  // corner coordinate sets, held in three registered slots per axis
  crd_t cy_q [3], cz_q [3];
  logic [2:0] cvalid_q;   // corner index was in range

  // one shared half-sum unit, one edge per cycle
  logic [1:0] e_f;
  logic signed [COORD_BITS:0] sx, sy, sz;
  assign e_f = (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
  assign sx = {cx_q[cnt_q][COORD_BITS-1], cx_q[cnt_q]} + {cx_q[e_f][COORD_BITS-1], cx_q[e_f]};
  assign sy = {cy_q[cnt_q][COORD_BITS-1], cy_q[cnt_q]} + {cy_q[e_f][COORD_BITS-1], cy_q[e_f]};
  assign sz = {cz_q[cnt_q][COORD_BITS-1], cz_q[cnt_q]} + {cz_q[e_f][COORD_BITS-1], cz_q[e_f]};

  // dictionary compare against all three midpoints
  logic [2:0] hit;
  always_comb begin
    for (int e = 0; e < 3; e++) begin
      hit[e] = (d_rd == {mz_q[e], my_q[e], mx_q[e]});
    end
  end

  // insertion space exhausted, and vertex index of the scanned dictionary entry
  logic            ins_full;
  logic [IdxW-1:0] idx_of_scan;
  assign ins_full = (nxt_q >= NxW'(MAX_VERTS)) || (dcnt_q >= CntW'(DICT_DEPTH));
  assign idx_of_scan = IdxW'(base_q + NxW'(scan_q));

  logic in_fire, out_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  // output select
  logic [IdxW-1:0] t0, t1, t2;
  always_comb begin
    case (cnt_q)
      2'd0: begin t0 = ia_q;      t1 = midx_q[0]; t2 = midx_q[2]; end
      2'd1: begin t0 = midx_q[2]; t1 = midx_q[1]; t2 = ic_q;      end
      2'd2: begin t0 = midx_q[0]; t1 = ib_q;      t2 = midx_q[1]; end
      default: begin t0 = midx_q[0]; t1 = midx_q[1]; t2 = midx_q[2]; end
    endcase
  end

  logic [OutCoordW-1:0] ox, oy, oz;
  assign ox = OutCoordW'($signed(mx_q[cnt_q]));
  assign oy = OutCoordW'($signed(my_q[cnt_q]));
  assign oz = OutCoordW'($signed(mz_q[cnt_q]));

  always_comb begin
    m_axis_tvalid = 1'b0;
    m_axis_tuser = 1'b0;
    m_axis_tlast = 1'b0;
    m_axis_tdata = '0;
    if (state_q == ST_EMIT_V) begin
      m_axis_tvalid = 1'b1;
      m_axis_tdata = {1'b0, full_q, oz, oy, ox, 20'd0, midx_q[cnt_q]};
    end else if (state_q == ST_EMIT_T) begin
      m_axis_tvalid = 1'b1;
      m_axis_tuser = 1'b1;
      m_axis_tlast = (cnt_q == 2'd3);
      m_axis_tdata = {1'b0, full_q, 72'd0, t2, t1, t0};
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    dcnt_d = dcnt_q;
    base_d = base_q;
    nxt_d = nxt_q;
    n0_d = n0_q;
    scan_d = scan_q;
    v_we = 1'b0;
    v_wa = '0;
    v_wd = {VecW{1'b0}};
    v_ra = '0;
    d_we = 1'b0;
    d_wa = DaW'(dcnt_q);
    d_wd = {mz_q[cnt_q], my_q[cnt_q], mx_q[cnt_q]};
    d_ra = DaW'(scan_q);
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            MODE_LOAD: begin
              v_we = (NxW'(in_a) < NxW'(MAX_VERTS));
              v_wa = VaW'(in_a);
              v_wd = {COORD_BITS'(s_axis_tdata[78 +: 24]),
                      COORD_BITS'(s_axis_tdata[54 +: 24]),
                      COORD_BITS'(s_axis_tdata[30 +: 24])};
            end
            MODE_PASS: begin
              dcnt_d = '0;
              base_d = NxW'(in_a);
              nxt_d = NxW'(in_a);
            end
            MODE_SUBDIV: begin
              state_d = ST_RD_REQ;
              cnt_d = 2'd0;
            end
            default: ;
          endcase
        end
      end
      ST_RD_REQ: begin
        v_ra = VaW'((cnt_q == 2'd0) ? ia_q : (cnt_q == 2'd1) ? ib_q : ic_q);
        state_d = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        // hold the address so the read data still shows this corner
        v_ra = VaW'((cnt_q == 2'd0) ? ia_q : (cnt_q == 2'd1) ? ib_q : ic_q);
        state_d = ST_RD_LATCH;
      end
      ST_RD_LATCH: begin
        if (cnt_q == 2'd2) begin
          cnt_d = 2'd0;
          state_d = ST_MID;
        end else begin
          cnt_d = cnt_q + 2'd1;
          state_d = ST_RD_REQ;
        end
      end
      ST_MID: begin
        if (cnt_q == 2'd2) begin
          n0_d = dcnt_q;
          scan_d = '0;
          cnt_d = 2'd0;
          state_d = (dcnt_q == '0) ? ST_INS : ST_SCAN;
        end else begin
          cnt_d = cnt_q + 2'd1;
        end
      end
      ST_SCAN: begin
        // address scan_q issued; data returns next cycle
        state_d = ST_SCAN_LAST;
      end
      ST_SCAN_LAST: begin
        d_ra = DaW'(scan_q + CntW'(1));
        scan_d = scan_q + CntW'(1);
        if (scan_q + CntW'(1) >= n0_q) state_d = ST_INS;
        else state_d = ST_SCAN_LAST;
      end
      ST_INS: begin
        if (found_q[cnt_q]) begin
          if (cnt_q == 2'd2) begin
            cnt_d = 2'd0;
            state_d = ST_EMIT_T;
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end else begin
          if (!ins_full) begin
            v_we = 1'b1;
            v_wa = VaW'(nxt_q);
            v_wd = {mz_q[cnt_q], my_q[cnt_q], mx_q[cnt_q]};
            d_we = 1'b1;
            nxt_d = nxt_q + NxW'(1);
            dcnt_d = dcnt_q + CntW'(1);
          end
          state_d = ST_EMIT_V;
        end
      end
      ST_EMIT_V: begin
        if (out_fire) begin
          if (cnt_q == 2'd2) begin
            cnt_d = 2'd0;
            state_d = ST_EMIT_T;
          end else begin
            cnt_d = cnt_q + 2'd1;
            state_d = ST_INS;
          end
        end
      end
      ST_EMIT_T: begin
        if (out_fire) begin
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
      dcnt_q <= '0;
      base_q <= '0;
      nxt_q <= '0;
      n0_q <= '0;
      scan_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      dcnt_q <= dcnt_d;
      base_q <= base_d;
      nxt_q <= nxt_d;
      n0_q <= n0_d;
      scan_q <= scan_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_fire) begin
      ia_q <= in_a;
      ib_q <= in_b;
      ic_q <= in_c;
      full_q <= 1'b0;
    end
    if (state_q == ST_RD_REQ) begin
      cvalid_q[cnt_q] <= (NxW'((cnt_q == 2'd0) ? ia_q : (cnt_q == 2'd1) ? ib_q : ic_q)
                          < NxW'(MAX_VERTS));
    end
    if (state_q == ST_RD_LATCH) begin
      cx_q[cnt_q] <= cvalid_q[cnt_q] ? v_rd[0 +: COORD_BITS] : '0;
      cy_q[cnt_q] <= cvalid_q[cnt_q] ? v_rd[COORD_BITS +: COORD_BITS] : '0;
      cz_q[cnt_q] <= cvalid_q[cnt_q] ? v_rd[2*COORD_BITS +: COORD_BITS] : '0;
    end
    if (state_q == ST_MID) begin
      mx_q[cnt_q] <= sx[COORD_BITS:1];
      my_q[cnt_q] <= sy[COORD_BITS:1];
      mz_q[cnt_q] <= sz[COORD_BITS:1];
      found_q[cnt_q] <= 1'b0;
      midx_q[cnt_q] <= '0;
    end
    if (state_q == ST_SCAN_LAST) begin
      // later entries overwrite earlier ones: highest position wins
      for (int e = 0; e < 3; e++) begin
        if (hit[e]) begin
          found_q[e] <= 1'b1;
          midx_q[e] <= idx_of_scan;
        end
      end
    end
    if (state_q == ST_INS && !found_q[cnt_q]) begin
      if (ins_full) begin
        full_q <= 1'b1;
        midx_q[cnt_q] <= '0;
      end else begin
        midx_q[cnt_q] <= IdxW'(nxt_q);
      end
    end
  end

  // assertions
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
  a_last_is_tri: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tlast |-> m_axis_tuser) else $error("last on vertex result");
  a_dict_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dcnt_q <= CntW'(DICT_DEPTH)) else $error("dictionary overfilled");
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && m_axis_tlast) |=> (state_q == ST_IDLE)) else $error("no return to idle");

endmodule
